// ===== sv/pnir_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pnir_pkg
// Shared widths and register indexes for the prism node index reorder block.
// ---------------------------------------------------------------------------
package pnir_pkg;

  // node index width on both channels
  localparam int INDEX_W = 12;

  // degree register width
  localparam int DEG_W = 4;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIANGLE_DEGREE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_DEGREE     = 1'd1;

endpackage
`default_nettype wire

// ===== sv/pnir_in_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pnir_in_if
// Input channel: one tensor-product node index per transfer.
// ---------------------------------------------------------------------------
interface pnir_in_if;
  logic                         valid;
  logic                         ready;
  logic [pnir_pkg::INDEX_W-1:0] node_index;

  modport source (output valid, output node_index, input ready);
  modport sink   (input valid, input node_index, output ready);
endinterface
`default_nettype wire

// ===== sv/pnir_out_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pnir_out_if
// Output channel: one topologically ordered index and error flag per transfer.
// ---------------------------------------------------------------------------
interface pnir_out_if;
  logic                         valid;
  logic                         ready;
  logic [pnir_pkg::INDEX_W-1:0] mapped_index;
  logic                         index_error;

  modport source (output valid, output mapped_index, output index_error, input ready);
  modport sink   (input valid, input mapped_index, input index_error, output ready);
endinterface
`default_nettype wire

// ===== sv/prism_node_index_reorder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// prism_node_index_reorder
// Maps a layer-major tensor-product node index of a prism element to its
// topological index (vertices, edges, faces, volume), flagging bad indices.
// ---------------------------------------------------------------------------
// Pipeline: five register stages from input transfer to result valid: input
//   register, two stages of two restoring division steps each, region decode,
//   then one multiply-add into the output register.
// Throughput: one index per cycle; a stalled output holds the pipe in place.
// Reset: synchronous, clears all stage valid bits and sets both degrees to 1.
// ---------------------------------------------------------------------------
module prism_node_index_reorder (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wen,
  input  wire [pnir_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [pnir_pkg::DEG_W-1:0]          cfg_wdata,
  pnir_in_if.sink                            node_in,
  pnir_out_if.source                         node_out
);

  // nodes in one triangle layer: (p+1)(p+2)/2
  function automatic logic [7:0] layer_nodes(input logic [pnir_pkg::DEG_W-1:0] p);
    logic [8:0] a;
    logic [8:0] b;
    logic [8:0] t;
    a = {5'd0, p} + 9'd1;
    b = {5'd0, p} + 9'd2;
    t = a * b;
    return t[8:1];
  endfunction

  // interior triangle face nodes: (p-1)(p-2)/2, none below degree 3
  function automatic logic [6:0] face_nodes(input logic [pnir_pkg::DEG_W-1:0] p);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] t;
    a = {4'd0, p} - 8'd1;
    b = {4'd0, p} - 8'd2;
    t = a * b;
    if (p < 4'd3) begin
      return 7'd0;
    end
    return t[7:1];
  endfunction

  // configuration registers
  logic [pnir_pkg::DEG_W-1:0] triangle_degree;
  logic [pnir_pkg::DEG_W-1:0] line_degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_degree <= 4'd1;
      line_degree     <= 4'd1;
    end else if (cfg_wen) begin
      case (cfg_addr)
        pnir_pkg::REG_TRIANGLE_DEGREE: triangle_degree <= cfg_wdata;
        pnir_pkg::REG_LINE_DEGREE:     line_degree     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // derived element constants
  logic [7:0]  nl;
  logic [3:0]  ne;
  logic [5:0]  npe;
  logic [6:0]  npf;
  logic [3:0]  nqe;
  logic [9:0]  npe_nqe;
  logic        deg_bad;

  assign nl      = layer_nodes(triangle_degree);
  assign ne      = triangle_degree - 4'd1;
  assign npe     = {2'd0, ne} + {1'b0, ne, 1'b0};
  assign npf     = face_nodes(triangle_degree);
  assign nqe     = line_degree - 4'd1;
  assign npe_nqe = {4'd0, npe} * {6'd0, nqe};
  assign deg_bad = (triangle_degree == 4'd0) || (line_degree == 4'd0);

  // stage valid bits and advance enables
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5 || node_out.ready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign node_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= node_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // stage 1: input register
  logic [pnir_pkg::INDEX_W-1:0] idx1;

  always_ff @(posedge clk) begin
    if (adv1) idx1 <= node_in.node_index;
  end

  // stage 1 to 2: overflow check and layer bits 3 and 2
  logic [12:0] nl13;
  logic [12:0] d3, d2;
  logic        ovf_c;
  logic        q3_c, q2_c;
  logic [11:0] rem_a, rem_b;

  assign nl13  = {5'd0, nl};
  assign d3    = nl13 << 3;
  assign d2    = nl13 << 2;
  assign ovf_c = {1'b0, idx1} >= (nl13 << 4);
  assign q3_c  = {1'b0, idx1} >= d3;
  assign rem_a = q3_c ? idx1 - d3[11:0] : idx1;
  assign q2_c  = {1'b0, rem_a} >= d2;
  assign rem_b = q2_c ? rem_a - d2[11:0] : rem_a;

  logic [11:0] rem2;
  logic [1:0]  lay_hi2;
  logic        ovf2;

  always_ff @(posedge clk) begin
    if (adv2) begin
      rem2    <= rem_b;
      lay_hi2 <= {q3_c, q2_c};
      ovf2    <= ovf_c;
    end
  end

  // stage 2 to 3: layer bits 1 and 0, remainder is the position in the layer
  logic [11:0] d1, d0;
  logic        q1_c, q0_c;
  logic [11:0] rem_c, rem_d;

  assign d1    = {3'd0, nl, 1'b0};
  assign d0    = {4'd0, nl};
  assign q1_c  = rem2 >= d1;
  assign rem_c = q1_c ? rem2 - d1 : rem2;
  assign q0_c  = rem_c >= d0;
  assign rem_d = q0_c ? rem_c - d0 : rem_c;

  logic [7:0] pos3;
  logic [3:0] layer3;
  logic       ovf3;

  always_ff @(posedge clk) begin
    if (adv3) begin
      pos3   <= rem_d[7:0];
      layer3 <= {lay_hi2, q1_c, q0_c};
      ovf3   <= ovf2;
    end
  end

  // stage 3 to 4: region decode into addend and multiply operands
  logic [11:0] pos_w, npe_w, npf_w, nqe3_w, nl2_w, base_w, lm1_w;
  logic [3:0]  lm1;
  logic [7:0]  m, m2;
  logic [5:0]  ne1_w, ne2_w;
  logic [5:0]  enqe;
  logic [5:0]  ofs;
  logic        err_c;
  logic [11:0] addend_c;
  logic [6:0]  mula_c;
  logic [5:0]  mulb_c;

  assign lm1    = layer3 - 4'd1;
  assign pos_w  = {4'd0, pos3};
  assign npe_w  = {6'd0, npe};
  assign npf_w  = {5'd0, npf};
  assign lm1_w  = {8'd0, lm1};
  assign nqe3_w = {8'd0, nqe} + {7'd0, nqe, 1'b0};
  assign nl2_w  = {3'd0, nl, 1'b0};
  assign base_w = nl2_w + nqe3_w;
  assign m      = pos3 - 8'd3;
  assign m2     = m - {2'd0, npe};
  assign ne1_w  = {2'd0, ne};
  assign ne2_w  = {1'b0, ne, 1'b0};

  // which of the three quad faces an edge-ring node belongs to
  always_comb begin
    if ({1'b0, m} >= {3'd0, ne2_w}) begin
      ofs      = ne2_w;
      enqe     = {1'b0, nqe, 1'b0};
    end else if ({1'b0, m} >= {3'd0, ne1_w}) begin
      ofs      = ne1_w;
      enqe     = {2'd0, nqe};
    end else begin
      ofs      = 6'd0;
      enqe     = 6'd0;
    end
  end

  always_comb begin
    err_c    = ovf3 || deg_bad || (layer3 > line_degree);
    addend_c = 12'd0;
    mula_c   = 7'd0;
    mulb_c   = 6'd0;
    if (layer3 == 4'd0) begin
      // base layer
      if (pos3 < 8'd3) begin
        addend_c = pos_w;
      end else if ({1'b0, pos3} < {3'd0, npe} + 9'd3) begin
        addend_c = pos_w + 12'd3;
      end else begin
        addend_c = pos_w + 12'd3 + npe_w + nqe3_w;
      end
    end else if (layer3 == line_degree) begin
      // top layer
      if (pos3 < 8'd3) begin
        addend_c = pos_w + 12'd3;
      end else if ({1'b0, pos3} < {3'd0, npe} + 9'd3) begin
        addend_c = pos_w + 12'd3 + npe_w;
      end else begin
        addend_c = pos_w + 12'd3 + npe_w + nqe3_w + npf_w;
      end
    end else if (pos3 < 8'd3) begin
      // vertical edge
      addend_c = 12'd6 + {npe_w[10:0], 1'b0} + lm1_w;
      mula_c   = {5'd0, pos3[1:0]};
      mulb_c   = {2'd0, nqe};
    end else if (m < {2'd0, npe}) begin
      // quad face
      addend_c = base_w + {4'd0, m} - {6'd0, ofs};
      mula_c   = {3'd0, ne};
      mulb_c   = enqe + {2'd0, lm1};
    end else if (m2 < {1'b0, npf}) begin
      // volume
      addend_c = base_w + {2'd0, npe_nqe} + {4'd0, m2};
      mula_c   = npf;
      mulb_c   = {2'd0, lm1};
    end else begin
      err_c = 1'b1;
    end
  end

  logic        err4;
  logic [11:0] addend4;
  logic [6:0]  mula4;
  logic [5:0]  mulb4;

  always_ff @(posedge clk) begin
    if (adv4) begin
      err4    <= err_c;
      addend4 <= addend_c;
      mula4   <= mula_c;
      mulb4   <= mulb_c;
    end
  end

  // stage 4 to 5: multiply-add into the output register
  logic [12:0] prod;
  logic [12:0] sum;

  assign prod = {6'd0, mula4} * {7'd0, mulb4};
  assign sum  = {1'b0, addend4} + prod;

  logic [pnir_pkg::INDEX_W-1:0] mapped5;
  logic                         err5;

  always_ff @(posedge clk) begin
    if (adv5) begin
      mapped5 <= err4 ? 12'd0 : sum[11:0];
      err5    <= err4;
    end
  end

  assign node_out.valid        = v5;
  assign node_out.mapped_index = mapped5;
  assign node_out.index_error  = err5;

endmodule
`default_nettype wire

// ===== sim/prism_node_index_reorder_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prism_node_index_reorder_test
// Streams node indices through the reorder block under a range of triangle
// and line degrees, predicts each topological index in the bench and checks
// every output transfer in order, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module prism_node_index_reorder_test;

  // one predicted output transfer, with the index that caused it
  typedef struct packed {
    logic [pnir_pkg::INDEX_W-1:0] node_index;
    logic [pnir_pkg::INDEX_W-1:0] mapped_index;
    logic                         index_error;
  } reorder_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_wen;
  logic [pnir_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [pnir_pkg::DEG_W-1:0]      cfg_wdata;

  pnir_in_if  node_in_ch ();
  pnir_out_if node_out_ch ();

  // bench copy of the degree registers
  logic [pnir_pkg::DEG_W-1:0] tri_deg;
  logic [pnir_pkg::DEG_W-1:0] line_deg;

  logic [pnir_pkg::INDEX_W-1:0] index_backlog[$];
  reorder_t                     reorder_expect[$];
  logic                         in_taken;
  int unsigned                  gap_pct;
  int unsigned                  fault_count;

  prism_node_index_reorder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .node_in   (node_in_ch),
    .node_out  (node_out_ch)
  );

  always #5 clk = ~clk;

  // number of nodes in the element, zero when a degree is zero
  function automatic int unsigned element_span(input int unsigned p, input int unsigned q);
    if (p == 0 || q == 0) return 0;
    return (p + 1) * (p + 2) / 2 * (q + 1);
  endfunction

  // topological position of one tensor-product node under the current degrees
  function automatic reorder_t predict_reorder(input logic [pnir_pkg::INDEX_W-1:0] idx);
    int unsigned p, q, ix, nl, npe, npf, nqe, layer, pos, m, ne, base, r;
    reorder_t    res;
    p   = 32'(tri_deg);
    q   = 32'(line_deg);
    ix  = 32'(idx);
    res.node_index   = idx;
    res.mapped_index = '0;
    res.index_error  = 1'b1;
    if (ix >= element_span(p, q)) return res;
    nl    = (p + 1) * (p + 2) / 2;
    npe   = 3 * (p - 1);
    npf   = (p >= 3) ? (p - 1) * (p - 2) / 2 : 0;
    nqe   = q - 1;
    layer = ix / nl;
    pos   = ix % nl;
    if (layer == 0) begin
      // base layer: vertices, edges, face
      if (pos < 3) r = pos;
      else if (pos < 3 + npe) r = pos + 3;
      else r = 6 + 2 * npe + 3 * nqe + (pos - 3 - npe);
    end else if (layer == q) begin
      // top layer
      if (pos < 3) r = pos + 3;
      else if (pos < 3 + npe) r = pos + 3 + npe;
      else r = 6 + 2 * npe + 3 * nqe + npf + (pos - 3 - npe);
    end else if (pos < 3) begin
      // vertical edge node
      r = 6 + 2 * npe + (layer - 1) + pos * nqe;
    end else begin
      m    = pos - 3;
      base = 2 * nl + 3 * nqe;
      if (m < npe) begin
        // quad face node
        ne = p - 1;
        r  = base + (m % ne) + (m / ne) * ne * nqe + (layer - 1) * ne;
      end else if (m - npe < npf) begin
        // volume node
        r = base + npe * nqe + (m - npe) + npf * (layer - 1);
      end else begin
        return res;
      end
    end
    res.mapped_index = r[pnir_pkg::INDEX_W-1:0];
    res.index_error  = 1'b0;
    return res;
  endfunction

  // write both degree registers while the block is idle
  task automatic load_degrees(input logic [pnir_pkg::DEG_W-1:0] p,
                              input logic [pnir_pkg::DEG_W-1:0] q);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= pnir_pkg::REG_TRIANGLE_DEGREE;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_addr  <= pnir_pkg::REG_LINE_DEGREE;
    cfg_wdata <= q;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    tri_deg  = p;
    line_deg = q;
    @(posedge clk);
  endtask

  // mostly in-element indices, some anywhere in the field
  task automatic queue_random(input int count);
    int unsigned span;
    span = element_span(32'(tri_deg), 32'(line_deg));
    repeat (count) begin
      if (span == 0 || $urandom_range(9) == 0)
        index_backlog.push_back(pnir_pkg::INDEX_W'($urandom_range(4095)));
      else
        index_backlog.push_back(pnir_pkg::INDEX_W'($urandom_range(span - 1)));
    end
  endtask

  // hold off until every queued index has come back, then let the pipe settle
  task automatic drain_results();
    while (index_backlog.size() != 0 || node_in_ch.valid || reorder_expect.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // input driver: present the next index once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      node_in_ch.valid <= 1'b0;
    end else if (!node_in_ch.valid || in_taken) begin
      if (index_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        node_in_ch.valid      <= 1'b1;
        node_in_ch.node_index <= index_backlog.pop_front();
      end else begin
        node_in_ch.valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    node_out_ch.ready <= ($urandom_range(99) >= gap_pct);
  end

  // record input transfers and check output transfers against the oldest prediction
  always @(posedge clk) begin
    reorder_t want;
    in_taken <= node_in_ch.valid && node_in_ch.ready && !rst;
    if (!rst && node_in_ch.valid && node_in_ch.ready)
      reorder_expect.push_back(predict_reorder(node_in_ch.node_index));
    if (!rst && node_out_ch.valid && node_out_ch.ready) begin
      if (reorder_expect.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected transfer: mapped_index %0d index_error %0b",
                   node_out_ch.mapped_index, node_out_ch.index_error);
        fault_count++;
      end else begin
        want = reorder_expect.pop_front();
        if (want.mapped_index !== node_out_ch.mapped_index ||
            want.index_error !== node_out_ch.index_error) begin
          if (fault_count < 10)
            $display("mismatch for node %0d (p=%0d q=%0d): expected %0d/%0b, got %0d/%0b",
                     want.node_index, tri_deg, line_deg, want.mapped_index,
                     want.index_error, node_out_ch.mapped_index, node_out_ch.index_error);
          fault_count++;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [pnir_pkg::DEG_W-1:0] p_sel, q_sel;
    rst                    = 1'b1;
    cfg_wen                = 1'b0;
    cfg_addr               = pnir_pkg::REG_TRIANGLE_DEGREE;
    cfg_wdata              = '0;
    node_in_ch.valid       = 1'b0;
    node_in_ch.node_index  = '0;
    node_out_ch.ready      = 1'b0;
    in_taken               = 1'b0;
    tri_deg                = 4'd1;
    line_deg               = 4'd1;
    gap_pct                = 10;
    fault_count            = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset degrees: three nodes, first index past the element, all ones
    index_backlog = '{12'd0, 12'd3, 12'd5, 12'd6, 12'hFFF};
    drain_results();

    // p=4 q=3: each region of base, middle and top layers, then the edge of range
    load_degrees(4'd4, 4'd3);
    index_backlog = '{12'd0, 12'd2, 12'd3, 12'd12, 12'd15, 12'd18,
                      12'd27, 12'd45, 12'd48, 12'd57, 12'd59, 12'd60};
    drain_results();

    // degree zero on either axis flags everything
    load_degrees(4'd0, 4'd5);
    index_backlog = '{12'd0, 12'hAAA};
    drain_results();
    load_degrees(4'd7, 4'd0);
    index_backlog = '{12'h555, 12'd1};
    drain_results();

    // largest element with no gaps, pausing the sender half way through
    gap_pct = 0;
    load_degrees(4'd15, 4'd15);
    queue_random(48);
    drain_results();
    queue_random(47);
    drain_results();
    gap_pct = 10;

    // extremes first, then random degrees
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin p_sel = 4'd1;  q_sel = 4'd15; end
        1: begin p_sel = 4'd15; q_sel = 4'd1;  end
        2: begin p_sel = 4'd2;  q_sel = 4'd2;  end
        3: begin p_sel = 4'd3;  q_sel = 4'd1;  end
        4: begin p_sel = 4'd1;  q_sel = 4'd1;  end
        5: begin p_sel = 4'd0;  q_sel = 4'd15; end
        6: begin p_sel = 4'd15; q_sel = 4'd0;  end
        default: begin
          p_sel = pnir_pkg::DEG_W'($urandom_range(15, 1));
          q_sel = pnir_pkg::DEG_W'($urandom_range(15, 1));
        end
      endcase
      load_degrees(p_sel, q_sel);
      queue_random((p_sel == 0 || q_sel == 0) ? 40 : 95);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (fault_count == 0 && reorder_expect.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pnir_pkg.sv
sv/pnir_in_if.sv
sv/pnir_out_if.sv
sv/prism_node_index_reorder.sv
sim/prism_node_index_reorder_test.sv
